// ===== rtl/ax25ahe_pkg.sv =====
// Shared types and constants for the AX.25 address header encoder.
// Used by the top level and by its port checker; depends on nothing.
package ax25ahe_pkg;

  localparam logic [2:0] CALLSIGN_CHARS = 3'd6;
  localparam logic [2:0] POS_MAX        = 3'd7;

  localparam logic [7:0] CHAR_END    = 8'h00;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [7:0] PAD_BYTE   = 8'h40;
  localparam logic [7:0] ADDR_BASE  = 8'hE0;
  localparam logic [7:0] CTRL_UI    = 8'h03;
  localparam logic [7:0] PID_NONE   = 8'hF0;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_address;
    logic       last_address;
    logic       parse_ssid;
    logic [3:0] ssid_value;
  } chr_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       header_end;
  } hdr_item_t;

  // Work still owed for one accepted item, unrolled one byte per cycle while the output is not stalled.
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_byte;
    logic [2:0] pads;
    logic       has_addr;
    logic [7:0] addr_byte;
    logic       has_ctrl;
    logic       has_pid;
  } run_t;

endpackage

// ===== rtl/ax25_address_header_encoder_top.sv =====
// An accepted item goes to the run register, then to the output register.
// Throughput: one header byte per cycle while hdr_stall is low; an item that
// gives at most one byte can be taken every such cycle, an end-of-address item
// holds input while the byte sequencer, which sets this figure, unrolls its run.
// Reset (rst, synchronous, active high) clears the address state, the pending
// run and the output valid flag.
module ax25_address_header_encoder_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    chr_valid,
  output logic                    chr_stall,
  input  ax25ahe_pkg::chr_item_t  chr_data,
  output logic                    hdr_valid,
  input  logic                    hdr_stall,
  output ax25ahe_pkg::hdr_item_t  hdr_data
);
  import ax25ahe_pkg::*;

  logic [2:0] text_position, text_position_next;
  logic [2:0] emitted_chars, emitted_chars_next;
  logic       hyphen_seen, hyphen_seen_next;
  logic       digits_stopped, digits_stopped_next;
  logic       text_ended, text_ended_next;
  logic [7:0] ssid_accumulator, ssid_accumulator_next;

  run_t       run, run_next, run_load, run_rest;
  logic       char_emit, is_digit, chr_accept;
  logic       out_free, run_busy, rest_busy;
  logic [3:0] ssid;
  logic [7:0] acc_step;
  hdr_item_t  hdr_next;

  // Address state update for the item on the input channel.
  always_comb begin
    text_position_next    = text_position;
    emitted_chars_next    = emitted_chars;
    hyphen_seen_next      = hyphen_seen;
    digits_stopped_next   = digits_stopped;
    text_ended_next       = text_ended;
    ssid_accumulator_next = ssid_accumulator;
    char_emit             = 1'b0;
    is_digit = (chr_data.ch >= CHAR_ZERO) && (chr_data.ch <= CHAR_NINE);
    acc_step = {ssid_accumulator[4:0], 3'b000} + {ssid_accumulator[6:0], 1'b0}
             + {4'b0000, chr_data.ch[3:0]};

    if (!text_ended) begin
      if (chr_data.ch == CHAR_END) begin
        text_ended_next = 1'b1;
      end else if (chr_data.parse_ssid) begin
        if (!hyphen_seen) begin
          if (text_position < CALLSIGN_CHARS) begin
            if (chr_data.ch == CHAR_HYPHEN) begin
              hyphen_seen_next = 1'b1;
            end else begin
              char_emit = emitted_chars < CALLSIGN_CHARS;
            end
          end
        end else if (!digits_stopped && text_position <= CALLSIGN_CHARS) begin
          if (is_digit) begin
            ssid_accumulator_next = acc_step;
          end else begin
            digits_stopped_next = 1'b1;
          end
        end
      end else if (text_position < CALLSIGN_CHARS) begin
        char_emit = emitted_chars < CALLSIGN_CHARS;
      end
    end

    emitted_chars_next = emitted_chars + {2'b00, char_emit};
    if (text_position < POS_MAX) begin
      text_position_next = text_position + 3'd1;
    end

    ssid = chr_data.parse_ssid ? ssid_accumulator_next[3:0] : chr_data.ssid_value;

    run_load           = '0;
    run_load.has_char  = char_emit;
    run_load.char_byte = {chr_data.ch[6:0], 1'b0};
    run_load.addr_byte = ADDR_BASE | {3'b000, ssid, chr_data.last_address};

    if (chr_data.end_of_address) begin
      run_load.pads       = CALLSIGN_CHARS - emitted_chars_next;
      run_load.has_addr   = 1'b1;
      run_load.has_ctrl   = chr_data.last_address;
      run_load.has_pid    = chr_data.last_address;
      text_position_next    = '0;
      emitted_chars_next    = '0;
      hyphen_seen_next      = 1'b0;
      digits_stopped_next   = 1'b0;
      text_ended_next       = 1'b0;
      ssid_accumulator_next = '0;
    end
  end

  // Byte sequencer: pick the next byte of the pending run.
  always_comb begin
    run_rest = run;
    hdr_next = '0;
    if (run.has_char) begin
      hdr_next.out_byte = run.char_byte;
      run_rest.has_char = 1'b0;
    end else if (run.pads != 3'd0) begin
      hdr_next.out_byte = PAD_BYTE;
      run_rest.pads     = run.pads - 3'd1;
    end else if (run.has_addr) begin
      hdr_next.out_byte = run.addr_byte;
      run_rest.has_addr = 1'b0;
    end else if (run.has_ctrl) begin
      hdr_next.out_byte = CTRL_UI;
      run_rest.has_ctrl = 1'b0;
    end else begin
      hdr_next.out_byte   = PID_NONE;
      hdr_next.header_end = 1'b1;
      run_rest.has_pid    = 1'b0;
    end
    run_busy  = run.has_char || (run.pads != 3'd0) || run.has_addr
             || run.has_ctrl || run.has_pid;
    rest_busy = run_rest.has_char || (run_rest.pads != 3'd0) || run_rest.has_addr
             || run_rest.has_ctrl || run_rest.has_pid;
    hdr_next.run_last = !rest_busy;
  end

  assign out_free   = !hdr_valid || !hdr_stall;
  assign chr_stall  = run_busy && !(out_free && !rest_busy);
  assign chr_accept = chr_valid && !chr_stall;

  always_comb begin
    run_next = run;
    if (chr_accept) begin
      run_next = run_load;
    end else if (out_free && run_busy) begin
      run_next = run_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position    <= '0;
      emitted_chars    <= '0;
      hyphen_seen      <= 1'b0;
      digits_stopped   <= 1'b0;
      text_ended       <= 1'b0;
      ssid_accumulator <= '0;
      run              <= '0;
      hdr_valid        <= 1'b0;
    end else begin
      if (chr_accept) begin
        text_position    <= text_position_next;
        emitted_chars    <= emitted_chars_next;
        hyphen_seen      <= hyphen_seen_next;
        digits_stopped   <= digits_stopped_next;
        text_ended       <= text_ended_next;
        ssid_accumulator <= ssid_accumulator_next;
      end
      run <= run_next;
      if (out_free) begin
        hdr_valid <= run_busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && run_busy) begin
      hdr_data <= hdr_next;
    end
  end

endmodule

// ===== rtl/ax25ahe_checker.sv =====
// Port checker for the AX.25 address header encoder, bound to the top level.
// Depends on ax25ahe_pkg for the item types and byte constants.
module ax25ahe_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    chr_stall,
  input logic                    hdr_valid,
  input logic                    hdr_stall,
  input ax25ahe_pkg::hdr_item_t  hdr_data
);
  import ax25ahe_pkg::*;

  // A stalled header byte stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_stall |=> hdr_valid && $stable(hdr_data))
    else $error("stalled header byte changed or dropped");

  // Nothing is shown on the output right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !hdr_valid)
    else $error("header output valid after reset");

  // With no run pending after reset, the input side is ready for an item.
  a_reset_ready: assert property (@(posedge clk) rst |=> !chr_stall)
    else $error("input stalled right after reset");

  // The PID byte is the only byte marked as header end, and it closes its run.
  a_pid: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_data.header_end |-> hdr_data.run_last &&
      (hdr_data.out_byte == PID_NONE))
    else $error("header end not on a closing PID byte");

  // An address byte with the last bit set does not close its run: control and PID follow.
  a_last_addr: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_data.out_byte[0] && (hdr_data.out_byte[7:5] == 3'b111)
      |-> !hdr_data.run_last)
    else $error("last address byte closed its run");

endmodule

bind ax25_address_header_encoder_top ax25ahe_checker u_ax25ahe_checker (
  .clk       (clk),
  .rst       (rst),
  .chr_stall (chr_stall),
  .hdr_valid (hdr_valid),
  .hdr_stall (hdr_stall),
  .hdr_data  (hdr_data)
);

// ===== test/tb.sv =====
// Self-checking testbench for the AX.25 address header encoder top level.
// Depends on ax25ahe_pkg for the item types and character constants; an
// internal encoder model predicts the header bytes of the untyped items.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ax25ahe_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int ROWS       = 24;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoa;
    logic       last;
    logic       parse;
    logic [3:0] ssid;
    logic       typed;
    logic [3:0] n;
    logic [7:0] b;
  } stim_row_t;

  logic      clk;
  logic      rst       = 1'b1;
  logic      chr_valid = 1'b0;
  logic      chr_stall;
  chr_item_t chr_data  = '0;
  logic      hdr_valid;
  logic      hdr_stall = 1'b0;
  hdr_item_t hdr_data;

  // Encoder model state.
  logic [2:0] txt_pos;
  logic [2:0] chars_out;
  bit         hyphen_seen;
  bit         digits_stopped;
  bit         txt_ended;
  logic [7:0] ssid_acc;

  hdr_item_t run_bytes[$];
  hdr_item_t header_bytes_due[$];

  int src_idle_pct  = 22;
  int sink_stall_pct = 54;
  int live_items;
  int error_count;
  int idle_cycles;

  // Directed rows: ch, end, last, parse, ssid, typed, byte count, byte.
  stim_row_t dir_rows [ROWS] = '{
    // Verbatim callsign longer than six characters.
    '{8'h41, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd1, 8'h82},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd1, 8'hFE},
    '{8'h80, 1'b0, 1'b1, 1'b0, 4'hA, 1'b1, 4'd1, 8'h00},
    '{8'h43, 1'b0, 1'b0, 1'b0, 4'h5, 1'b1, 4'd1, 8'h86},
    '{8'h44, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd1, 8'h88},
    '{8'h45, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd1, 8'h8A},
    '{8'h46, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h47, 1'b1, 1'b0, 1'b0, 4'hF, 1'b1, 4'd1, 8'hFE},
    // Parsed SSID, text closed by a NUL on the end item.
    '{8'h4B, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd1, 8'h96},
    '{8'h2D, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h31, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h32, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h00, 1'b1, 1'b1, 1'b1, 4'h0, 1'b0, 4'd0, 8'h00},
    // Characters after an early NUL are dropped.
    '{8'h00, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h58, 1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h59, 1'b1, 1'b0, 1'b0, 4'h0, 1'b0, 4'd0, 8'h00},
    // A non-digit stops the SSID digits.
    '{8'h41, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd1, 8'h82},
    '{8'h2D, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h39, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h78, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h35, 1'b1, 1'b1, 1'b1, 4'h3, 1'b0, 4'd0, 8'h00},
    // Mode switches inside one address, then a lone hyphen address.
    '{8'h2D, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 4'd0, 8'h00},
    '{8'h37, 1'b1, 1'b0, 1'b0, 4'h7, 1'b0, 4'd0, 8'h00},
    '{8'h2D, 1'b1, 1'b1, 1'b1, 4'h0, 1'b0, 4'd0, 8'h00}
  };

  ax25_address_header_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_data  (chr_data),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr_data  (hdr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_byte(input logic [7:0] b, input logic pid);
    hdr_item_t r;
    r.out_byte   = b;
    r.run_last   = 1'b0;
    r.header_end = pid;
    run_bytes.push_back(r);
  endfunction

  function automatic void add_callsign(input logic [7:0] c);
    if (chars_out < CALLSIGN_CHARS) begin
      add_byte({c[6:0], 1'b0}, 1'b0);
      chars_out++;
    end
  endfunction

  function automatic void clear_address();
    txt_pos        = '0;
    chars_out      = '0;
    hyphen_seen    = 1'b0;
    digits_stopped = 1'b0;
    txt_ended      = 1'b0;
    ssid_acc       = '0;
  endfunction

  // Header bytes caused by one character item, left in run_bytes.
  function automatic void encode_item(input chr_item_t it);
    logic [3:0] ssid;
    run_bytes.delete();
    if (!txt_ended) begin
      if (it.ch == CHAR_END) begin
        txt_ended = 1'b1;
      end else if (it.parse_ssid) begin
        if (!hyphen_seen) begin
          if (txt_pos < CALLSIGN_CHARS) begin
            if (it.ch == CHAR_HYPHEN) hyphen_seen = 1'b1;
            else add_callsign(it.ch);
          end
        end else if (!digits_stopped && txt_pos <= CALLSIGN_CHARS) begin
          if (it.ch >= CHAR_ZERO && it.ch <= CHAR_NINE) begin
            ssid_acc = ssid_acc * 8'd10 + (it.ch - CHAR_ZERO);
          end else begin
            digits_stopped = 1'b1;
          end
        end
      end else if (txt_pos < CALLSIGN_CHARS) begin
        add_callsign(it.ch);
      end
    end
    if (txt_pos < POS_MAX) txt_pos++;
    if (it.end_of_address) begin
      ssid = it.parse_ssid ? ssid_acc[3:0] : it.ssid_value;
      while (chars_out < CALLSIGN_CHARS) begin
        add_byte(PAD_BYTE, 1'b0);
        chars_out++;
      end
      add_byte(ADDR_BASE | {3'b000, ssid, it.last_address}, 1'b0);
      if (it.last_address) begin
        add_byte(CTRL_UI, 1'b0);
        add_byte(PID_NONE, 1'b1);
      end
      clear_address();
    end
    if (run_bytes.size() > 0) run_bytes[$].run_last = 1'b1;
  endfunction

  // Present one item, wait for it to be taken, then queue what it must produce.
  // A typed row supplies its expected byte directly instead of the model's.
  task automatic send_char(input chr_item_t it, input stim_row_t row);
    hdr_item_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      chr_valid <= 1'b0;
      @(posedge clk);
    end
    chr_valid <= 1'b1;
    chr_data  <= it;
    @(posedge clk);
    while (chr_stall) @(posedge clk);
    if (!txt_ended || it.end_of_address) live_items++;
    encode_item(it);
    if (row.typed) begin
      if (row.n != 0) begin
        r.out_byte   = row.b;
        r.run_last   = 1'b1;
        r.header_end = 1'b0;
        header_bytes_due.push_back(r);
      end
    end else begin
      foreach (run_bytes[k]) header_bytes_due.push_back(run_bytes[k]);
    end
  endtask

  // One address as a sender would form it, with some corruption mixed in.
  task automatic random_address();
    logic [7:0] text[$];
    chr_item_t  it;
    stim_row_t  no_row;
    bit         parse;
    int         len;
    int         ndig;
    int         pick;
    no_row = '0;
    parse  = 1'($urandom_range(1));
    len    = ($urandom_range(4) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 6);
    repeat (len) begin
      if ($urandom_range(3) == 0) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
      else text.push_back(8'(8'h41 + $urandom_range(25)));
    end
    if (parse && $urandom_range(3) != 0) begin
      text.push_back(CHAR_HYPHEN);
      ndig = $urandom_range(1, 4);
      repeat (ndig) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    end
    if (text.size() == 0) text.push_back(CHAR_END);
    if ($urandom_range(7) == 0) begin
      pick = $urandom_range(text.size() - 1);
      text[pick] = ($urandom_range(1) == 0) ? CHAR_END : 8'($urandom_range(255));
    end
    foreach (text[k]) begin
      it.ch             = text[k];
      it.end_of_address = (k == text.size() - 1);
      it.last_address   = ($urandom_range(2) == 0);
      it.parse_ssid     = ($urandom_range(9) == 0) ? !parse : parse;
      it.ssid_value     = 4'($urandom_range(15));
      send_char(it, no_row);
    end
  endtask

  task automatic drain_results();
    while (header_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall and in-order comparison of every taken byte.
  always @(posedge clk) begin
    hdr_item_t want;
    if (rst) begin
      hdr_stall <= 1'b0;
    end else begin
      hdr_stall <= ($urandom_range(99) < sink_stall_pct);
    end
    if (!rst && hdr_valid && !hdr_stall) begin
      if (header_bytes_due.size() == 0) begin
        $error("unexpected header byte %h", hdr_data.out_byte);
        error_count++;
      end else begin
        want = header_bytes_due.pop_front();
        if (hdr_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, hdr_data.out_byte);
          error_count++;
        end
        if (hdr_data.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, hdr_data.run_last);
          error_count++;
        end
        if (hdr_data.header_end !== want.header_end) begin
          $error("header_end: expected %b, got %b", want.header_end, hdr_data.header_end);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (chr_valid && !chr_stall) || (hdr_valid && !hdr_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    chr_item_t it;
    int        target;
    live_items  = 0;
    clear_address();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      it = {dir_rows[k].ch, dir_rows[k].eoa, dir_rows[k].last,
            dir_rows[k].parse, dir_rows[k].ssid};
      send_char(it, dir_rows[k]);
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct   = 54;
        sink_stall_pct = 22;
      end else if (phase == 2) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      target = live_items + 52;
      while (live_items < target) random_address();
      // Hold the sender off until every byte owed so far has come out.
      chr_valid <= 1'b0;
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
